// ===== hdl/stli_pkg.sv =====
// package: types, constants and helpers for the sorted table interpolator
`timescale 1ns / 1ps
package stli_pkg;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned KeyWidth   = 40;
  localparam int unsigned NumQty     = 6;
  localparam int unsigned AddrWidth  = $clog2(TableDepth);
  localparam int unsigned CountWidth = $clog2(TableDepth + 1);
  localparam int unsigned RowWidth   = KeyWidth + NumQty * ValueWidth;
  localparam int unsigned MinInterp  = 2;
  // magnitude of a difference and the exact product width
  localparam int unsigned DiffWidth  = ValueWidth + 1;
  localparam int unsigned ProdWidth  = ValueWidth + KeyWidth;

  localparam logic [2:0] StStored   = 3'd0;
  localparam logic [2:0] StExact    = 3'd1;
  localparam logic [2:0] StInterp   = 3'd2;
  localparam logic [2:0] StOutside  = 3'd3;
  localparam logic [2:0] StTooFew   = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef logic signed [ValueWidth-1:0] val_t;

  typedef struct packed {
    logic                cmd;
    logic [KeyWidth-1:0] time_key;
    val_t                polar_x;
    val_t                polar_y;
    val_t                ut1_minus_utc;
    val_t                length_of_day;
    val_t                pole_offset_x;
    val_t                pole_offset_y;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    val_t       out_polar_x;
    val_t       out_polar_y;
    val_t       out_ut1_minus_utc;
    val_t       out_length_of_day;
    val_t       out_pole_offset_x;
    val_t       out_pole_offset_y;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 load_req;    // capture the request
    logic                 rd_en;       // read row at rd_addr
    logic [AddrWidth-1:0] rd_addr;
    logic                 cap_hi;      // registered read data is the upper entry
    logic                 cap_lo;      // registered read data is the lower entry
    logic                 wr_en;
    logic [AddrWidth-1:0] wr_addr;
    logic                 wr_shift;    // write last read row instead of request
    logic                 div_start;
    logic                 out_load;
    logic [2:0]           out_status;
    logic                 out_hit;     // result from upper entry as is
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic                cmd;
    logic [KeyWidth-1:0] key;
    logic [KeyWidth-1:0] rd_key;    // key of registered read row
    logic                div_busy;
  } sts_t;

endpackage

// ===== hdl/stli_ram.sv =====
// generic simple dual port ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
module stli_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/stli_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module stli_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [stli_pkg::ProdWidth-1:0]        dividend_i,
  input  logic [stli_pkg::KeyWidth-1:0]         divisor_i,
  output logic                                  busy_o,
  output logic [stli_pkg::ProdWidth-1:0]        quot_o
);
  import stli_pkg::*;

  localparam int unsigned CntWidth = $clog2(ProdWidth + 1);

  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [KeyWidth:0]    rem_q, rem_d;
  logic [ProdWidth-1:0] quo_q, quo_d;
  logic [KeyWidth-1:0]  dvs_q, dvs_d;
  logic [KeyWidth:0]    trial;

  // one shift and subtract step
  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q[KeyWidth-1:0], quo_q[ProdWidth-1]};
    if (start_i) begin
      cnt_d = CntWidth'(ProdWidth);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[ProdWidth-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[ProdWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

// ===== hdl/stli_datapath.sv =====
// datapath: table memory, request capture, interpolation and result register
`timescale 1ns / 1ps
module stli_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stli_pkg::req_t   req_i,
  input  stli_pkg::ctl_t   ctl_i,
  output stli_pkg::sts_t   sts_o,
  output stli_pkg::rsp_t   rsp_o
);
  import stli_pkg::*;

  localparam int unsigned QtyIdxW = $clog2(NumQty);
  localparam int unsigned HalfKey = KeyWidth / 2;

  req_t                 req_q;
  logic [RowWidth-1:0]  rd_row;
  logic [RowWidth-1:0]  wr_row;
  logic [RowWidth-1:0]  hi_q, lo_q;
  val_t                 res_q [NumQty];
  logic [QtyIdxW-1:0]   qi_q, qi_d;
  logic                 run_q, run_d;
  logic                 wait_q, wait_d;
  logic                 mul_q, mul_d;
  logic                 mul2_q;
  logic [ProdWidth-1:0] prod_q;
  logic                 neg_q;
  logic [KeyWidth-1:0]  span_q;
  logic                 div_busy;
  logic [ProdWidth-1:0] quot;
  val_t                 v0, v1;
  logic signed [DiffWidth-1:0] diff;
  logic [DiffWidth-1:0] mag;
  logic [KeyWidth-1:0]  dt;
  val_t                 v0_q;
  logic [DiffWidth-1:0] mag_q;
  logic [HalfKey-1:0]   dt_hi_q;
  logic [DiffWidth-1:0] mul_a;
  logic [HalfKey-1:0]   mul_b;
  logic [DiffWidth+HalfKey-1:0] pp;
  logic                 qty_done;

  function automatic val_t row_val(logic [RowWidth-1:0] row, logic [QtyIdxW-1:0] idx);
    row_val = val_t'(row[(NumQty-1-int'(idx))*ValueWidth +: ValueWidth]);
  endfunction

  assign wr_row = ctl_i.wr_shift ? rd_row :
                  {req_q.time_key, req_q.polar_x, req_q.polar_y, req_q.ut1_minus_utc,
                   req_q.length_of_day, req_q.pole_offset_x, req_q.pole_offset_y};

  stli_ram #(.Width(RowWidth), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (ctl_i.wr_addr),
    .wdata_i (wr_row),
    .re_i    (ctl_i.rd_en),
    .raddr_i (ctl_i.rd_addr),
    .rdata_o (rd_row)
  );

  // request and bracket capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_req) req_q <= req_i;
    if (ctl_i.cap_hi) hi_q <= rd_row;
    if (ctl_i.cap_lo) lo_q <= rd_row;
  end

  // per quantity operands for the quantity about to start
  assign v0   = row_val(lo_q, qi_d);
  assign v1   = row_val(hi_q, qi_d);
  assign diff = DiffWidth'(v1) - DiffWidth'(v0);
  assign mag  = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
  assign dt   = req_q.time_key - lo_q[RowWidth-1 -: KeyWidth];

  // one narrow multiplier, low half of dt first, high half next cycle
  assign mul_a = mul_q ? mag_q : mag;
  assign mul_b = mul_q ? dt_hi_q : dt[HalfKey-1:0];
  assign pp    = mul_a * mul_b;

  stli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul2_q),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign qty_done = run_q && wait_q && !div_busy && !mul_q && !mul2_q;

  // quantity sequencer: multiply, then divide, then store the result
  always_comb begin
    qi_d   = qi_q;
    run_d  = run_q;
    mul_d  = 1'b0;
    wait_d = wait_q;
    if (ctl_i.div_start) begin
      run_d = 1'b1;
      qi_d  = '0;
      mul_d = 1'b1;
    end else if (qty_done) begin
      wait_d = 1'b0;
      if (qi_q == QtyIdxW'(NumQty - 1)) begin
        run_d = 1'b0;
      end else begin
        qi_d  = qi_q + 1'b1;
        mul_d = 1'b1;
      end
    end
    if (mul_q) wait_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qi_q   <= '0;
      run_q  <= 1'b0;
      wait_q <= 1'b0;
      mul_q  <= 1'b0;
      mul2_q <= 1'b0;
    end else begin
      qi_q   <= qi_d;
      run_q  <= run_d;
      wait_q <= wait_d;
      mul_q  <= mul_d;
      mul2_q <= mul_q;
    end
  end

  // product register feeding the divider, and per quantity result register
  always_ff @(posedge clk_i) begin
    if (mul_d) begin
      prod_q  <= ProdWidth'(pp);
      mag_q   <= mag;
      dt_hi_q <= dt[KeyWidth-1:HalfKey];
      neg_q   <= diff[DiffWidth-1];
      v0_q    <= v0;
      span_q  <= hi_q[RowWidth-1 -: KeyWidth] - lo_q[RowWidth-1 -: KeyWidth];
    end else if (mul_q) begin
      prod_q <= prod_q + ProdWidth'({pp, {HalfKey{1'b0}}});
    end
    if (qty_done) begin
      res_q[qi_q] <= neg_q ? val_t'(v0_q - val_t'(quot)) : val_t'(v0_q + val_t'(quot));
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      rsp_o.status <= ctl_i.out_status;
      if (ctl_i.out_hit) begin
        rsp_o.out_polar_x       <= row_val(hi_q, 3'd0);
        rsp_o.out_polar_y       <= row_val(hi_q, 3'd1);
        rsp_o.out_ut1_minus_utc <= row_val(hi_q, 3'd2);
        rsp_o.out_length_of_day <= row_val(hi_q, 3'd3);
        rsp_o.out_pole_offset_x <= row_val(hi_q, 3'd4);
        rsp_o.out_pole_offset_y <= row_val(hi_q, 3'd5);
      end else if (ctl_i.out_status == StInterp) begin
        rsp_o.out_polar_x       <= res_q[0];
        rsp_o.out_polar_y       <= res_q[1];
        rsp_o.out_ut1_minus_utc <= res_q[2];
        rsp_o.out_length_of_day <= res_q[3];
        rsp_o.out_pole_offset_x <= res_q[4];
        rsp_o.out_pole_offset_y <= res_q[5];
      end else begin
        rsp_o.out_polar_x       <= '0;
        rsp_o.out_polar_y       <= '0;
        rsp_o.out_ut1_minus_utc <= '0;
        rsp_o.out_length_of_day <= '0;
        rsp_o.out_pole_offset_x <= '0;
        rsp_o.out_pole_offset_y <= '0;
      end
    end
  end

  assign sts_o.cmd      = req_q.cmd;
  assign sts_o.key      = req_q.time_key;
  assign sts_o.rd_key   = rd_row[RowWidth-1 -: KeyWidth];
  assign sts_o.div_busy = run_q;

endmodule

// ===== hdl/stli_ctrl.sv =====
// controller: search, shift, write and result sequencing
`timescale 1ns / 1ps
module stli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  stli_pkg::sts_t   sts_i,
  output stli_pkg::ctl_t   ctl_o
);
  import stli_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_LORD  = 4'd6;
  localparam logic [3:0] S_LOCAP = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_DIVGO = 4'd11;

  logic [3:0]            state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] pos_q, pos_d;
  logic [CountWidth-1:0] idx_q, idx_d;
  logic [KeyWidth-1:0]   first_q, first_d, last_q, last_d;
  logic                  hit_q, hit_d;
  logic                  ovalid_q, ovalid_d;
  logic [2:0]            st_q, st_d;
  logic                  outside;

  assign outside = (count_q == '0) || (sts_i.key < first_q) || (sts_i.key > last_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    first_d  = first_q;
    last_d   = last_q;
    hit_d    = hit_q;
    st_d     = st_q;
    ovalid_d = ovalid_q && out_stall_i;
    ctl_o    = '0;
    ctl_o.out_status = st_q;
    ctl_o.out_hit    = hit_q;
    ctl_o.rd_addr    = pos_q[AddrWidth-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_req = 1'b1;
          pos_d   = '0;
          hit_d   = 1'b0;
          state_d = S_RD;
        end
      end
      // linear search: read entry at pos
      S_RD: begin
        if (pos_q >= count_q) begin
          state_d = S_DEC;
        end else begin
          ctl_o.rd_en = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctl_o.cap_hi = 1'b1;
        if (sts_i.rd_key < sts_i.key) begin
          pos_d   = pos_q + 1'b1;
          state_d = S_RD;
        end else begin
          hit_d   = (sts_i.rd_key == sts_i.key);
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.cmd == CmdInsert) begin
          if (hit_q) begin
            ctl_o.wr_en   = 1'b1;
            ctl_o.wr_addr = pos_q[AddrWidth-1:0];
            st_d    = StStored;
            hit_d   = 1'b0;
            state_d = S_OUT;
          end else if (count_q >= CountWidth'(TableDepth)) begin
            st_d    = StFull;
            state_d = S_OUT;
          end else begin
            idx_d   = count_q;
            state_d = S_SHRD;
          end
        end else if (outside) begin
          st_d = StOutside; hit_d = 1'b0; state_d = S_OUT;
        end else if (hit_q) begin
          st_d = StExact; state_d = S_OUT;
        end else if (count_q <= CountWidth'(MinInterp) || pos_q == '0) begin
          st_d = (pos_q == '0) ? StOutside : StTooFew;
          state_d = S_OUT;
        end else begin
          state_d = S_LORD;
        end
      end
      // shift entries up by one from the top
      S_SHRD: begin
        if (idx_q == pos_q) begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_addr = pos_q[AddrWidth-1:0];
          count_d = count_q + 1'b1;
          if (count_q == '0) begin
            first_d = sts_i.key; last_d = sts_i.key;
          end else if (sts_i.key < first_q) begin
            first_d = sts_i.key;
          end else if (sts_i.key > last_q) begin
            last_d = sts_i.key;
          end
          st_d    = StStored;
          state_d = S_OUT;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = AddrWidth'(idx_q - 1'b1);
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl_o.wr_en    = 1'b1;
        ctl_o.wr_shift = 1'b1;
        ctl_o.wr_addr  = idx_q[AddrWidth-1:0];
        idx_d   = idx_q - 1'b1;
        state_d = S_SHRD;
      end
      // fetch lower bracket and run the divider
      S_LORD: begin
        ctl_o.rd_en   = 1'b1;
        ctl_o.rd_addr = AddrWidth'(pos_q - 1'b1);
        state_d = S_LOCAP;
      end
      S_LOCAP: begin
        ctl_o.cap_lo = 1'b1;
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        ctl_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!sts_i.div_busy) begin
          st_d = StInterp; state_d = S_OUT;
        end
      end
      // load result once the output register is free
      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      first_q  <= '0;
      last_q   <= '0;
      hit_q    <= 1'b0;
      st_q     <= StStored;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
      last_q   <= last_d;
      hit_q    <= hit_d;
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  // entry count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CountWidth'(TableDepth))
    else $error("entry count above depth");
  // count grows by at most one per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == $past(count_q) || count_q == $past(count_q) + 1'b1)
    else $error("entry count jumped");
  // span bounds ordered once the table holds entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != '0 |-> first_q <= last_q)
    else $error("first key above last key");

endmodule

// ===== hdl/sorted_table_linear_interpolator.sv =====
// top level: sorted time-keyed table with linear interpolation
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | stli_pkg::req_t
//   out     | output    | out_valid/out_stall| stli_pkg::rsp_t
// one request at a time; a linear search reads one table row at a time, in
// a read state then a compare state. insert of a new key shifts every later
// row up by one, each with a read state then a write state, from the top.
// interpolation, after the search: per quantity, a product in two halves of
// dt, a 72-step divide and one update, for all six quantities in turn.
// reset empties the table at once; no clearing pass. a stalled result holds.
`timescale 1ns / 1ps
module sorted_table_linear_interpolator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  stli_pkg::req_t in_data_i,
  output logic           out_valid,
  input  logic           out_stall,
  output stli_pkg::rsp_t out_data_o
);
  import stli_pkg::*;

  ctl_t ctl;
  sts_t sts;

  stli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  stli_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );

endmodule
